### rtl/fse_pkg.sv
// Package with the parser mode type and the character class functions.
package fse_pkg;

	typedef enum logic [2:0] {
		M_NORMAL  = 3'd0,
		M_PERCENT = 3'd1,
		M_FLAGS   = 3'd2,
		M_WIDTH   = 3'd3,
		M_PREC    = 3'd4,
		M_LEN1    = 3'd5,
		M_LEN2    = 3'd6,
		M_STOPPED = 3'd7
	} mode_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	function automatic logic is_flag(input logic [7:0] c);
		case (c) inside
			"-", "+", " ", "#", "0": is_flag = 1'b1;
			default:                 is_flag = 1'b0;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_len1(input logic [7:0] c);
		case (c) inside
			"h", "l", "L", "z", "j", "t": is_len1 = 1'b1;
			default:                      is_len1 = 1'b0;
		endcase
	endfunction

	function automatic logic is_len2(input logic [7:0] c);
		case (c) inside
			"h", "l", "L": is_len2 = 1'b1;
			default:       is_len2 = 1'b0;
		endcase
	endfunction

	function automatic logic is_conv(input logic [7:0] c);
		case (c) inside
			"d", "i", "o", "u", "x", "X", "f", "F", "e", "E",
			"g", "G", "a", "A", "c", "s", "p", "n": is_conv = 1'b1;
			default:                                is_conv = 1'b0;
		endcase
	endfunction

endpackage

### rtl/format_spec_extractor.sv
// Streaming printf conversion specifier recognizer.
// An accepted item passes through the input register and then the result
// register, which loads a result only when the output can take it.
// Throughput: one item per cycle; tready falls only while a result waits.
// Reset clears the parser mode, counters and all valid flags; payload
// registers are left uninitialized.
module format_spec_extractor #(
	parameter int MAX_SPECS = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] conv_letter, [14:8] spec_count,
	                                   // [15] specs_dropped
	output logic        m_axis_tuser,  // [0] spec_found
	output logic        m_axis_tlast
);

	localparam int CNT_W = $clog2(MAX_SPECS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPECS);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;

	fse_pkg::mode_t   mode_q;
	fse_pkg::mode_t   mode_nxt;
	fse_pkg::mode_t   spec_mode;
	logic             start_q;
	logic             start_nxt;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] kept_nxt;
	logic             dropped_q;
	logic             dropped_nxt;

	logic             conv;
	logic             kept;
	logic             produce;
	logic             adv;
	logic [CNT_W+6:0] count_ext;

	logic             out_valid_q;
	logic             found_q;
	logic [7:0]       letter_q;
	logic             done_q;
	logic [6:0]       count_q;
	logic             drop_q;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Character step inside a specifier: each stage falls into the next one
	// when the character does not belong to it.
	always_comb begin
		spec_mode = mode_q;
		conv      = 1'b0;
		mode_nxt  = mode_q;
		start_nxt = 1'b0;
		if (mode_q == fse_pkg::M_STOPPED) begin
			mode_nxt = fse_pkg::M_STOPPED;
		end else if (ch_s1 == fse_pkg::CH_NUL) begin
			mode_nxt = fse_pkg::M_STOPPED;
		end else if (start_q && mode_q == fse_pkg::M_NORMAL &&
				ch_s1 == fse_pkg::CH_PERCENT) begin
			mode_nxt  = fse_pkg::M_PERCENT;
			start_nxt = 1'b1;
		end else if (start_q && mode_q == fse_pkg::M_PERCENT &&
				ch_s1 == fse_pkg::CH_SPACE) begin
			mode_nxt = fse_pkg::M_NORMAL;
		end else if (mode_q == fse_pkg::M_NORMAL) begin
			mode_nxt = (ch_s1 == fse_pkg::CH_PERCENT) ? fse_pkg::M_PERCENT
				: fse_pkg::M_NORMAL;
		end else if (mode_q == fse_pkg::M_PERCENT && ch_s1 == fse_pkg::CH_PERCENT) begin
			mode_nxt = fse_pkg::M_NORMAL;
		end else begin
			if (spec_mode == fse_pkg::M_PERCENT) begin
				spec_mode = fse_pkg::M_FLAGS;
			end
			if (spec_mode == fse_pkg::M_FLAGS && !fse_pkg::is_flag(ch_s1)) begin
				spec_mode = fse_pkg::M_WIDTH;
			end
			if (spec_mode == fse_pkg::M_FLAGS) begin
				mode_nxt = fse_pkg::M_FLAGS;
			end else if (spec_mode == fse_pkg::M_WIDTH && fse_pkg::is_digit(ch_s1)) begin
				mode_nxt = fse_pkg::M_WIDTH;
			end else if (spec_mode == fse_pkg::M_WIDTH && ch_s1 == fse_pkg::CH_DOT) begin
				mode_nxt = fse_pkg::M_PREC;
			end else if (spec_mode == fse_pkg::M_PREC && fse_pkg::is_digit(ch_s1)) begin
				mode_nxt = fse_pkg::M_PREC;
			end else if ((spec_mode == fse_pkg::M_WIDTH || spec_mode == fse_pkg::M_PREC) &&
					fse_pkg::is_len1(ch_s1)) begin
				mode_nxt = fse_pkg::M_LEN1;
			end else if (spec_mode == fse_pkg::M_LEN1 && fse_pkg::is_len2(ch_s1)) begin
				mode_nxt = fse_pkg::M_LEN2;
			end else if (fse_pkg::is_conv(ch_s1)) begin
				conv     = 1'b1;
				mode_nxt = fse_pkg::M_NORMAL;
			end else begin
				mode_nxt = (ch_s1 == fse_pkg::CH_PERCENT) ? fse_pkg::M_PERCENT
					: fse_pkg::M_NORMAL;
			end
		end
	end

	always_comb begin
		kept        = conv && (kept_q < MAX_CNT);
		kept_nxt    = kept ? kept_q + CNT_W'(1) : kept_q;
		dropped_nxt = dropped_q || (conv && !kept);
		produce     = kept || last_s1;
		count_ext   = {7'd0, kept_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= fse_pkg::M_NORMAL;
			start_q     <= 1'b1;
			kept_q      <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= produce;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (last_s1) begin
					mode_q    <= fse_pkg::M_NORMAL;
					start_q   <= 1'b1;
					kept_q    <= '0;
					dropped_q <= 1'b0;
				end else begin
					mode_q    <= mode_nxt;
					start_q   <= start_nxt;
					kept_q    <= kept_nxt;
					dropped_q <= dropped_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv && produce) begin
			found_q  <= kept;
			letter_q <= kept ? ch_s1 : 8'd0;
			done_q   <= last_s1;
			count_q  <= count_ext[6:0];
			drop_q   <= dropped_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {drop_q, count_q, letter_q};
	assign m_axis_tuser  = found_q;
	assign m_axis_tlast  = done_q;

	a_kept_limit: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= MAX_CNT)
		else $error("kept count above limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> kept_q == '0 && !dropped_q && start_q &&
			mode_q == fse_pkg::M_NORMAL)
		else $error("state not cleared after last item");

	a_drop_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> kept_q == MAX_CNT)
		else $error("drop flagged below limit");

	a_found_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] != 8'd0)
		else $error("found specifier with empty letter");

	a_result_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
		else $error("result with neither specifier nor end");

endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming printf conversion specifier recognizer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fse_pkg::*;

	localparam int MAX_KEPT = 127;
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic       found;
		logic [7:0] letter;
		logic       done;
		logic [6:0] count;
		logic       dropped;
	} spec_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] ch
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // [7:0] conv_letter, [14:8] spec_count,
	                                    // [15] specs_dropped
	logic        m_axis_tuser;          // [0] spec_found
	logic        m_axis_tlast;

	spec_report_t pending_reports[$];
	logic [7:0]   token_buf[$];

	mode_t       parse_state;
	bit          string_start;
	int unsigned kept_specs;
	bit          specs_lost;

	int          fail_count = 0;
	int unsigned chars_sent = 0;
	int unsigned send_idle_max = 17;
	int unsigned rcv_idle_max = 17;
	bit          hold_request = 1'b0;

	format_spec_extractor #(
		.MAX_SPECS(MAX_KEPT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic bit char_in(logic [7:0] c, string set);
		for (int i = 0; i < set.len(); i++) begin
			if (set[i] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_char(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic bit is_decimal(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic mode_t advance_spec(mode_t m, logic [7:0] c, output bit conv);
		mode_t cur;
		cur = m;
		conv = 1'b0;
		if (cur == M_PERCENT) begin
			if (c == CH_PERCENT)
				return M_NORMAL;
			cur = M_FLAGS;
		end
		if (cur == M_FLAGS) begin
			if (char_in(c, "-+ #0"))
				return M_FLAGS;
			cur = M_WIDTH;
		end
		if (cur == M_WIDTH) begin
			if (is_decimal(c))
				return M_WIDTH;
			if (c == CH_DOT)
				return M_PREC;
			if (char_in(c, "hlLzjt"))
				return M_LEN1;
		end else if (cur == M_PREC) begin
			if (is_decimal(c))
				return M_PREC;
			if (char_in(c, "hlLzjt"))
				return M_LEN1;
		end else if (cur == M_LEN1) begin
			if (char_in(c, "hlL"))
				return M_LEN2;
		end
		if (char_in(c, "diouxXfFeEgGaAcspn")) begin
			conv = 1'b1;
			return M_NORMAL;
		end
		return (c == CH_PERCENT) ? M_PERCENT : M_NORMAL;
	endfunction

	function automatic void clear_parser();
		parse_state = M_NORMAL;
		string_start = 1'b1;
		kept_specs = 0;
		specs_lost = 1'b0;
	endfunction

	function automatic void predict_char(logic [7:0] c, bit last);
		bit first;
		bit conv;
		bit kept;
		spec_report_t rep;
		first = string_start;
		conv = 1'b0;
		kept = 1'b0;
		string_start = 1'b0;
		if (parse_state != M_STOPPED) begin
			if (c == CH_NUL) begin
				parse_state = M_STOPPED;
			end else if (first && parse_state == M_NORMAL && c == CH_PERCENT) begin
				parse_state = M_PERCENT;
				string_start = 1'b1;
			end else if (first && parse_state == M_PERCENT && c == CH_SPACE) begin
				parse_state = M_NORMAL;
			end else if (parse_state == M_NORMAL) begin
				if (c == CH_PERCENT)
					parse_state = M_PERCENT;
			end else begin
				parse_state = advance_spec(parse_state, c, conv);
			end
		end
		if (conv) begin
			if (kept_specs < MAX_KEPT) begin
				kept_specs++;
				kept = 1'b1;
			end else begin
				specs_lost = 1'b1;
			end
		end
		if (kept || last) begin
			rep.found = kept;
			rep.letter = kept ? c : 8'd0;
			rep.done = last;
			rep.count = 7'(kept_specs);
			rep.dropped = specs_lost;
			pending_reports.push_back(rep);
		end
		if (last)
			clear_parser();
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic send_char(input logic [7:0] c, input bit last);
		int unsigned gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_char(c, last);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], ends && (i == s.len() - 1));
	endtask

	task automatic send_buffer();
		for (int i = 0; i < token_buf.size(); i++)
			send_char(token_buf[i], i == token_buf.size() - 1);
		token_buf.delete();
	endtask

	task automatic add_spec(input bit well_formed);
		logic [7:0] len1;
		token_buf.push_back(CH_PERCENT);
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) token_buf.push_back(pick_char("-+ #0"));
		if ($urandom_range(0, 1) == 1)
			repeat ($urandom_range(1, 3)) token_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 2) == 0) begin
			token_buf.push_back(CH_DOT);
			repeat ($urandom_range(0, 2)) token_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 2) == 0) begin
			len1 = pick_char("hlLzjt");
			token_buf.push_back(len1);
			if (char_in(len1, "hlL") && $urandom_range(0, 1) == 1)
				token_buf.push_back(pick_char("hlL"));
		end
		if (well_formed)
			token_buf.push_back(pick_char("diouxXfFeEgGaAcspn"));
		else
			token_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_random_token();
		int unsigned kind;
		kind = $urandom_range(0, 31);
		if (kind < 18) begin
			add_spec(1'b1);
		end else if (kind < 22) begin
			add_spec(1'b0);
		end else if (kind < 24) begin
			token_buf.push_back(CH_PERCENT);
			token_buf.push_back(CH_PERCENT);
		end else if (kind < 28) begin
			repeat ($urandom_range(1, 4)) token_buf.push_back(8'($urandom_range(32, 126)));
		end else if (kind < 31) begin
			repeat ($urandom_range(1, 3)) token_buf.push_back(8'($urandom_range(1, 255)));
		end else begin
			token_buf.push_back(CH_NUL);
		end
	endtask

	task automatic test_specifier_forms();
		send_text("%-+ #05.3lld", 1'b0);
		send_text("%hhx%zu%.f", 1'b0);
		send_text("%Lg", 1'b1);
	endtask

	task automatic test_escape_and_prefix();
		send_text("% d%%s", 1'b1);
		send_text("%%d", 1'b1);
	endtask

	task automatic test_rejected_letters();
		send_text("%5q%d", 1'b0);
		send_text("%5%i", 1'b1);
	endtask

	task automatic test_nul_and_open_end();
		send_text("%c", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_text("%d", 1'b1);
		send_text("a%5", 1'b1);
	endtask

	task automatic test_high_bytes();
		send_char(8'hff, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(CH_PERCENT, 1'b0);
		send_char(8'hc8, 1'b1);
	endtask

	task automatic test_spec_limit();
		repeat (MAX_KEPT + 3) send_text("%d", 1'b0);
		send_text("x", 1'b1);
	endtask

	task automatic test_output_stall();
		send_idle_max = 0;
		hold_request = 1'b1;
		repeat (40) send_text("%s", 1'b0);
		send_text("%p", 1'b1);
		send_idle_max = 17;
	endtask

	task automatic test_random_strings();
		int unsigned first_char;
		int unsigned tokens;
		first_char = chars_sent;
		while (chars_sent - first_char < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       send_idle_max = 0;
				1:       send_idle_max = 4;
				default: send_idle_max = 17;
			endcase
			case ($urandom_range(0, 3))
				0:       rcv_idle_max = 0;
				1:       rcv_idle_max = 4;
				default: rcv_idle_max = 17;
			endcase
			tokens = ($urandom_range(0, 59) == 0) ? $urandom_range(130, 140) : $urandom_range(1, 8);
			if ($urandom_range(0, 4) == 0) begin
				token_buf.push_back(CH_PERCENT);
				token_buf.push_back(CH_SPACE);
			end
			repeat (tokens) add_random_token();
			send_buffer();
		end
	endtask

	initial begin : result_checker
		int unsigned stall;
		spec_report_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = $urandom_range(0, rcv_idle_max);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (pending_reports.size() == 0) begin
				$error("result item with no expected result: tdata %0h, tuser %0d, tlast %0d",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("spec_found", want.found, m_axis_tuser);
				check_field("conv_letter", want.letter, m_axis_tdata[7:0]);
				check_field("string_done", want.done, m_axis_tlast);
				check_field("spec_count", want.count, m_axis_tdata[14:8]);
				check_field("specs_dropped", want.dropped, m_axis_tdata[15]);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_specifier_forms();
		test_escape_and_prefix();
		test_rejected_letters();
		test_nul_and_open_end();
		test_high_bytes();
		test_spec_limit();
		test_output_stall();
		test_random_strings();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
